// File: design/mpct_pkg.sv
// ----------------------------------------------------------------------------
// mpct_pkg
// shared constants, codes and beat types of the midi channel state tracker
// ----------------------------------------------------------------------------
package mpct_pkg;

    localparam int CHANNELS   = 16;
    localparam int KEYS       = 128;
    localparam int CTRL_COUNT = 128;

    // key words live below CTRL_BASE, controller words at CTRL_BASE and above it
    localparam int CTRL_BASE = CHANNELS * KEYS;
    localparam int TBL_DEPTH = CHANNELS * (KEYS + CTRL_COUNT);
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // key word: note state, velocity, key pressure (controller value in low bits)
    localparam int KEY_W  = 15;
    // channel word: bend, channel pressure, program
    localparam int CHAN_W = 28;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam logic [7:0] ST_SYSEX = 8'hF0;
    localparam logic [7:0] ST_MTC   = 8'hF1;
    localparam logic [7:0] ST_SPP   = 8'hF2;
    localparam logic [7:0] ST_SONG  = 8'hF3;
    localparam logic [7:0] ST_TUNE  = 8'hF6;
    localparam logic [7:0] ST_EOX   = 8'hF7;
    localparam logic [7:0] ST_CLOCK = 8'hF8;
    localparam logic [7:0] ST_START = 8'hFA;
    localparam logic [7:0] ST_CONT  = 8'hFB;
    localparam logic [7:0] ST_STOP  = 8'hFC;
    localparam logic [7:0] ST_SENSE = 8'hFE;
    localparam logic [7:0] ST_RESET = 8'hFF;
    localparam logic [7:0] ST_NONE  = 8'h00;

    localparam logic [3:0] HI_NOTE_OFF = 4'h8;
    localparam logic [3:0] HI_NOTE_ON  = 4'h9;
    localparam logic [3:0] HI_KEYPRESS = 4'hA;
    localparam logic [3:0] HI_CTRL     = 4'hB;
    localparam logic [3:0] HI_PROG     = 4'hC;
    localparam logic [3:0] HI_CHPRESS  = 4'hD;
    localparam logic [3:0] HI_BEND     = 4'hE;

    typedef enum logic [4:0] {
        EV_NOTE     = 5'd0,
        EV_VELOCITY = 5'd1,
        EV_KEYPRESS = 5'd2,
        EV_CTRL     = 5'd3,
        EV_PROG     = 5'd4,
        EV_CHPRESS  = 5'd5,
        EV_BEND     = 5'd6,
        EV_MTC      = 5'd7,
        EV_SPP      = 5'd8,
        EV_SONG     = 5'd9,
        EV_TUNE     = 5'd10,
        EV_CLOCK    = 5'd11,
        EV_START    = 5'd12,
        EV_CONT     = 5'd13,
        EV_STOP     = 5'd14,
        EV_SENSE    = 5'd15,
        EV_RESET    = 5'd16,
        EV_ERROR    = 5'd17
    } ev_kind_t;

    typedef enum logic [2:0] {
        OP_DIRECT,
        OP_NOTE,
        OP_KEYPRESS,
        OP_CTRL,
        OP_PROG,
        OP_CHPRESS,
        OP_BEND
    } op_code_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic [3:0]  ch;
        logic [6:0]  idx;
        logic [13:0] val;
        logic        last;
    } event_t;

    typedef struct packed {
        op_code_t          code;
        ev_kind_t          kind;
        logic [3:0]        ch;
        logic [6:0]        idx;
        logic [13:0]       val;
        logic              note_on;
        logic [TBL_AW-1:0] addr;
    } op_req_t;

    typedef struct packed {
        logic [1:0] cnt;
        event_t     ev0;
        event_t     ev1;
    } ev_push_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } tbl_status_t;

endpackage

// File: design/mpct_parser.sv
// ----------------------------------------------------------------------------
// mpct_parser
// running status byte parser, turns complete messages into table requests
// ----------------------------------------------------------------------------
module mpct_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        midi_byte,
    output logic              op_valid,
    output mpct_pkg::op_req_t op
);

    logic [7:0] rs_reg, rs_next;
    logic [6:0] first_reg, first_next;
    logic       held_reg, held_next;
    logic       sysex_reg, sysex_next;

    logic [3:0] hi;
    logic [3:0] ch;
    logic       need2;
    logic [6:0] d1;
    logic [6:0] d2;
    logic       key_ok;
    logic       ch_ok;
    logic [mpct_pkg::TBL_AW-1:0] key_addr;
    logic [mpct_pkg::TBL_AW-1:0] ctrl_addr;

    assign hi    = rs_reg[7:4];
    assign ch    = rs_reg[3:0];
    assign need2 = !(hi == mpct_pkg::HI_PROG || hi == mpct_pkg::HI_CHPRESS ||
                     rs_reg == mpct_pkg::ST_MTC || rs_reg == mpct_pkg::ST_SONG);
    assign d1    = need2 ? first_reg : midi_byte[6:0];
    assign d2    = midi_byte[6:0];
    assign key_ok = 32'(d1) < mpct_pkg::KEYS;
    assign ch_ok  = 32'(ch) < mpct_pkg::CHANNELS;
    assign key_addr  = mpct_pkg::TBL_AW'(32'(ch) * mpct_pkg::KEYS + 32'(d1));
    assign ctrl_addr = mpct_pkg::TBL_AW'(mpct_pkg::CTRL_BASE +
                       32'(ch) * mpct_pkg::CTRL_COUNT + 32'(d1));

    always_comb begin
        rs_next    = rs_reg;
        first_next = first_reg;
        held_next  = held_reg;
        sysex_next = sysex_reg;
        op         = '0;
        op_valid   = 1'b0;
        if (accept) begin
            if (midi_byte >= mpct_pkg::ST_CLOCK) begin
                // realtime, parser state untouched unless undefined
                op_valid = 1'b1;
                op.code  = mpct_pkg::OP_DIRECT;
                case (midi_byte)
                    mpct_pkg::ST_CLOCK: op.kind = mpct_pkg::EV_CLOCK;
                    mpct_pkg::ST_START: op.kind = mpct_pkg::EV_START;
                    mpct_pkg::ST_CONT:  op.kind = mpct_pkg::EV_CONT;
                    mpct_pkg::ST_STOP:  op.kind = mpct_pkg::EV_STOP;
                    mpct_pkg::ST_SENSE: op.kind = mpct_pkg::EV_SENSE;
                    mpct_pkg::ST_RESET: op.kind = mpct_pkg::EV_RESET;
                    default: begin
                        op.kind    = mpct_pkg::EV_ERROR;
                        rs_next    = mpct_pkg::ST_NONE;
                        held_next  = 1'b0;
                        sysex_next = 1'b0;
                    end
                endcase
            end else if (midi_byte[7]) begin
                held_next  = 1'b0;
                sysex_next = 1'b0;
                op.code    = mpct_pkg::OP_DIRECT;
                if (midi_byte < mpct_pkg::ST_SYSEX) begin
                    rs_next = midi_byte;
                end else begin
                    case (midi_byte)
                        mpct_pkg::ST_SYSEX: begin
                            rs_next    = mpct_pkg::ST_NONE;
                            sysex_next = 1'b1;
                        end
                        mpct_pkg::ST_EOX: begin
                            rs_next  = mpct_pkg::ST_NONE;
                            op_valid = !sysex_reg;
                            op.kind  = mpct_pkg::EV_ERROR;
                        end
                        mpct_pkg::ST_MTC, mpct_pkg::ST_SPP, mpct_pkg::ST_SONG: begin
                            rs_next = midi_byte;
                        end
                        mpct_pkg::ST_TUNE: begin
                            rs_next  = mpct_pkg::ST_NONE;
                            op_valid = 1'b1;
                            op.kind  = mpct_pkg::EV_TUNE;
                        end
                        default: begin
                            rs_next  = mpct_pkg::ST_NONE;
                            op_valid = 1'b1;
                            op.kind  = mpct_pkg::EV_ERROR;
                        end
                    endcase
                end
            end else if (!sysex_reg && rs_reg != mpct_pkg::ST_NONE) begin
                if (need2 && !held_reg) begin
                    first_next = midi_byte[6:0];
                    held_next  = 1'b1;
                end else begin
                    held_next = 1'b0;
                    op.ch     = ch;
                    op.idx    = d1;
                    op.val    = {7'd0, d2};
                    case (rs_reg)
                        mpct_pkg::ST_MTC: begin
                            rs_next  = mpct_pkg::ST_NONE;
                            op_valid = 1'b1;
                            op.code  = mpct_pkg::OP_DIRECT;
                            op.kind  = mpct_pkg::EV_MTC;
                            op.ch    = 4'd0;
                            op.idx   = {4'd0, midi_byte[6:4]};
                            op.val   = {10'd0, midi_byte[3:0]};
                        end
                        mpct_pkg::ST_SPP: begin
                            rs_next  = mpct_pkg::ST_NONE;
                            op_valid = 1'b1;
                            op.code  = mpct_pkg::OP_DIRECT;
                            op.kind  = mpct_pkg::EV_SPP;
                            op.ch    = 4'd0;
                            op.idx   = 7'd0;
                            op.val   = {d2, d1};
                        end
                        mpct_pkg::ST_SONG: begin
                            rs_next  = mpct_pkg::ST_NONE;
                            op_valid = 1'b1;
                            op.code  = mpct_pkg::OP_DIRECT;
                            op.kind  = mpct_pkg::EV_SONG;
                            op.ch    = 4'd0;
                            op.idx   = 7'd0;
                        end
                        default: begin
                            op.addr = key_addr;
                            case (hi)
                                mpct_pkg::HI_NOTE_OFF, mpct_pkg::HI_NOTE_ON: begin
                                    op_valid   = ch_ok && key_ok;
                                    op.code    = mpct_pkg::OP_NOTE;
                                    op.note_on = (hi == mpct_pkg::HI_NOTE_ON) && (d2 != 7'd0);
                                end
                                mpct_pkg::HI_KEYPRESS: begin
                                    op_valid = ch_ok && key_ok;
                                    op.code  = mpct_pkg::OP_KEYPRESS;
                                end
                                mpct_pkg::HI_CTRL: begin
                                    op_valid = ch_ok;
                                    op.code  = mpct_pkg::OP_CTRL;
                                    op.addr  = ctrl_addr;
                                end
                                mpct_pkg::HI_PROG: begin
                                    op_valid = ch_ok;
                                    op.code  = mpct_pkg::OP_PROG;
                                    op.idx   = 7'd0;
                                end
                                mpct_pkg::HI_CHPRESS: begin
                                    op_valid = ch_ok;
                                    op.code  = mpct_pkg::OP_CHPRESS;
                                    op.idx   = 7'd0;
                                end
                                default: begin
                                    op_valid = ch_ok;
                                    op.code  = mpct_pkg::OP_BEND;
                                    op.idx   = 7'd0;
                                    op.val   = {d2, d1};
                                end
                            endcase
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_reg    <= mpct_pkg::ST_NONE;
            first_reg <= 7'd0;
            held_reg  <= 1'b0;
            sysex_reg <= 1'b0;
        end else begin
            rs_reg    <= rs_next;
            first_reg <= first_next;
            held_reg  <= held_next;
            sysex_reg <= sysex_next;
        end
    end

endmodule

// File: design/mpct_table.sv
// ----------------------------------------------------------------------------
// mpct_table
// key/controller and channel memories, read then compare and write back
// ----------------------------------------------------------------------------
module mpct_table (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  op_valid,
    input  mpct_pkg::op_req_t     op,
    output mpct_pkg::ev_push_t    push,
    output mpct_pkg::tbl_status_t status
);

    logic [mpct_pkg::KEY_W-1:0]  key_mem  [mpct_pkg::TBL_DEPTH];
    logic [mpct_pkg::CHAN_W-1:0] chan_mem [mpct_pkg::CHANNELS];

    logic [mpct_pkg::KEY_W-1:0]  key_rd_reg;
    logic [mpct_pkg::CHAN_W-1:0] chan_rd_reg;

    logic                        s1_valid_reg;
    mpct_pkg::op_req_t           s1_reg;

    logic                        clear_reg;
    logic [mpct_pkg::TBL_AW-1:0] clr_addr_reg;

    logic                        kfwd_valid_reg;
    logic [mpct_pkg::TBL_AW-1:0] kfwd_addr_reg;
    logic [mpct_pkg::KEY_W-1:0]  kfwd_data_reg;
    logic                        cfwd_valid_reg;
    logic [3:0]                  cfwd_ch_reg;
    logic [mpct_pkg::CHAN_W-1:0] cfwd_data_reg;

    logic [mpct_pkg::KEY_W-1:0]  key_word;
    logic [mpct_pkg::CHAN_W-1:0] chan_word;
    logic [mpct_pkg::KEY_W-1:0]  key_new;
    logic [mpct_pkg::CHAN_W-1:0] chan_new;
    logic                        key_wr;
    logic                        chan_wr;
    logic                        clr_chan;
    mpct_pkg::event_t            ev_a;
    mpct_pkg::event_t            ev_b;
    logic [1:0]                  cnt;

    // bypass the write of the previous cycle when the read saw old data
    assign key_word  = (kfwd_valid_reg && kfwd_addr_reg == s1_reg.addr) ?
                       kfwd_data_reg : key_rd_reg;
    assign chan_word = (cfwd_valid_reg && cfwd_ch_reg == s1_reg.ch) ?
                       cfwd_data_reg : chan_rd_reg;
    assign clr_chan  = 32'(clr_addr_reg) < mpct_pkg::CHANNELS;

    always_comb begin
        key_new  = key_word;
        chan_new = chan_word;
        key_wr   = 1'b0;
        chan_wr  = 1'b0;
        cnt      = 2'd0;
        ev_a     = '0;
        ev_b     = '0;
        ev_a.ch  = s1_reg.ch;
        ev_a.idx = s1_reg.idx;
        ev_b.ch  = s1_reg.ch;
        ev_b.idx = s1_reg.idx;
        case (s1_reg.code)
            mpct_pkg::OP_DIRECT: begin
                cnt      = 2'd1;
                ev_a.kind = s1_reg.kind;
                ev_a.val  = s1_reg.val;
            end
            mpct_pkg::OP_NOTE: begin
                key_wr  = 1'b1;
                key_new = {s1_reg.note_on, s1_reg.val[6:0], key_word[6:0]};
                if (key_word[14] != s1_reg.note_on) begin
                    ev_a.kind = mpct_pkg::EV_NOTE;
                    ev_a.val  = {13'd0, s1_reg.note_on};
                    ev_b.kind = mpct_pkg::EV_VELOCITY;
                    ev_b.val  = s1_reg.val;
                    cnt       = (key_word[13:7] != s1_reg.val[6:0]) ? 2'd2 : 2'd1;
                end else begin
                    ev_a.kind = mpct_pkg::EV_VELOCITY;
                    ev_a.val  = s1_reg.val;
                    cnt       = (key_word[13:7] != s1_reg.val[6:0]) ? 2'd1 : 2'd0;
                end
            end
            mpct_pkg::OP_KEYPRESS, mpct_pkg::OP_CTRL: begin
                key_wr    = 1'b1;
                key_new   = {key_word[14:7], s1_reg.val[6:0]};
                ev_a.kind = (s1_reg.code == mpct_pkg::OP_CTRL) ?
                            mpct_pkg::EV_CTRL : mpct_pkg::EV_KEYPRESS;
                ev_a.val  = s1_reg.val;
                cnt       = (key_word[6:0] != s1_reg.val[6:0]) ? 2'd1 : 2'd0;
            end
            mpct_pkg::OP_PROG: begin
                chan_wr   = 1'b1;
                chan_new  = {chan_word[27:7], s1_reg.val[6:0]};
                ev_a.kind = mpct_pkg::EV_PROG;
                ev_a.val  = s1_reg.val;
                cnt       = (chan_word[6:0] != s1_reg.val[6:0]) ? 2'd1 : 2'd0;
            end
            mpct_pkg::OP_CHPRESS: begin
                chan_wr   = 1'b1;
                chan_new  = {chan_word[27:14], s1_reg.val[6:0], chan_word[6:0]};
                ev_a.kind = mpct_pkg::EV_CHPRESS;
                ev_a.val  = s1_reg.val;
                cnt       = (chan_word[13:7] != s1_reg.val[6:0]) ? 2'd1 : 2'd0;
            end
            mpct_pkg::OP_BEND: begin
                chan_wr   = 1'b1;
                chan_new  = {s1_reg.val, chan_word[13:0]};
                ev_a.kind = mpct_pkg::EV_BEND;
                ev_a.val  = s1_reg.val;
                cnt       = (chan_word[27:14] != s1_reg.val) ? 2'd1 : 2'd0;
            end
            default: begin
                cnt = 2'd0;
            end
        endcase
        ev_a.last = (cnt == 2'd1);
        ev_b.last = (cnt == 2'd2);
        if (!s1_valid_reg) begin
            cnt     = 2'd0;
            key_wr  = 1'b0;
            chan_wr = 1'b0;
        end
    end

    assign push.cnt        = cnt;
    assign push.ev0        = ev_a;
    assign push.ev1        = ev_b;
    assign status.clearing = clear_reg;
    assign status.busy     = s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (clear_reg) begin
            key_mem[clr_addr_reg] <= '0;
        end else if (key_wr) begin
            key_mem[s1_reg.addr] <= key_new;
        end
        if (op_valid) begin
            key_rd_reg <= key_mem[op.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (clear_reg && clr_chan) begin
            chan_mem[clr_addr_reg[mpct_pkg::CH_AW-1:0]] <= '0;
        end else if (chan_wr) begin
            chan_mem[s1_reg.ch[mpct_pkg::CH_AW-1:0]] <= chan_new;
        end
        if (op_valid) begin
            chan_rd_reg <= chan_mem[op.ch[mpct_pkg::CH_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (op_valid) begin
            s1_reg <= op;
        end
        if (key_wr) begin
            kfwd_addr_reg <= s1_reg.addr;
            kfwd_data_reg <= key_new;
        end
        if (chan_wr) begin
            cfwd_ch_reg   <= s1_reg.ch;
            cfwd_data_reg <= chan_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            clear_reg      <= 1'b1;
            clr_addr_reg   <= '0;
            kfwd_valid_reg <= 1'b0;
            cfwd_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= op_valid;
            if (clear_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == mpct_pkg::TBL_AW'(mpct_pkg::TBL_DEPTH - 1)) begin
                    clear_reg <= 1'b0;
                end
            end
            if (key_wr) begin
                kfwd_valid_reg <= 1'b1;
            end
            if (chan_wr) begin
                cfwd_valid_reg <= 1'b1;
            end
        end
    end

    a_no_op_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        op_valid |-> !clear_reg)
        else $error("table request during clearing pass");

    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !clear_reg |=> !clear_reg)
        else $error("clearing pass restarted without reset");

    a_direct_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_reg.code == mpct_pkg::OP_DIRECT) |-> cnt == 2'd1)
        else $error("direct event not pushed exactly once");

endmodule

// File: design/mpct_event_fifo.sv
// ----------------------------------------------------------------------------
// mpct_event_fifo
// small event queue, takes up to two events per cycle, gives one per beat
// ----------------------------------------------------------------------------
module mpct_event_fifo (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mpct_pkg::ev_push_t           push,
    output logic                         out_valid,
    input  logic                         out_ready,
    output mpct_pkg::event_t             out_event,
    output logic [mpct_pkg::FIFO_CW-1:0] count
);

    mpct_pkg::event_t             q_reg [mpct_pkg::FIFO_DEPTH];
    logic [mpct_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [mpct_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [mpct_pkg::FIFO_CW-1:0] count_reg;
    logic [mpct_pkg::FIFO_AW-1:0] wr_ptr_b;
    logic                         pop;

    assign out_valid = count_reg != '0;
    assign out_event = q_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign count     = count_reg;
    assign wr_ptr_b  = wr_ptr_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            q_reg[wr_ptr_reg] <= push.ev0;
        end
        if (push.cnt == 2'd2) begin
            q_reg[wr_ptr_b] <= push.ev1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + mpct_pkg::FIFO_AW'(push.cnt);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + mpct_pkg::FIFO_CW'(push.cnt) -
                         mpct_pkg::FIFO_CW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(count_reg) + 32'(push.cnt)) <= mpct_pkg::FIFO_DEPTH)
        else $error("event queue overflow");

endmodule

// File: design/midi_parser_channel_state_tracker.sv
// ----------------------------------------------------------------------------
// midi_parser_channel_state_tracker
// midi running status parser with per-channel change events
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser      | tlast
//  s_      | in  | [7:0] midi_byte               | -          | -
//  m_      | out | [3:0] ch [10:4] idx [24:11] val| [4:0] kind | last_of_run
//
//  a byte is parsed as it enters and its table read is registered; compare/write-back
//  uses it with a bypass of the last write and queues the resulting events for m_
//  s_tready needs room in the 4-event queue for two events per byte in flight:
//  empty queue, one byte per cycle; one or two queued, a byte only while the table stage is idle
//  after reset a clearing pass sweeps all 4096 words of the key/controller memory
//  (and the channel memory) with s_tready low
//  m_tready low fills the queue; s_tready then falls until it drains
// ----------------------------------------------------------------------------
module midi_parser_channel_state_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] midi_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [3:0] event_channel, [10:4] event_index, [24:11] event_value
    output logic [4:0]  m_tuser,   // [4:0] event_kind
    output logic        m_tlast    // last_of_run
);

    logic                         accept;
    logic                         op_valid;
    mpct_pkg::op_req_t            op;
    mpct_pkg::ev_push_t           push;
    mpct_pkg::tbl_status_t        status;
    mpct_pkg::event_t             head;
    logic [mpct_pkg::FIFO_CW-1:0] fifo_count;
    logic [mpct_pkg::FIFO_CW:0]   need;

    assign need     = {1'b0, fifo_count} + (status.busy ? (mpct_pkg::FIFO_CW+1)'(2) : '0) +
                      (mpct_pkg::FIFO_CW+1)'(2);
    assign s_tready = !status.clearing && (32'(need) <= mpct_pkg::FIFO_DEPTH);
    assign accept   = s_tvalid && s_tready;

    mpct_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .midi_byte (s_tdata),
        .op_valid  (op_valid),
        .op        (op)
    );

    mpct_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (op_valid),
        .op       (op),
        .push     (push),
        .status   (status)
    );

    mpct_event_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_event (head),
        .count     (fifo_count)
    );

    assign m_tdata = {7'd0, head.val, head.idx, head.ch};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule
